### hw/rtl/ahfd_pkg.sv
// Package for the ASCII hex frame deframer with CRC-8 check.
// Holds the character codes, result codes, register map and the digit and CRC functions.
// No dependencies.
`default_nettype none

package ahfd_pkg;

	// Counter width default, fixed field width and minimum pair count
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int POS_WIDTH       = 16;
	localparam int MIN_PAIRS       = 4;

	// Configuration port
	localparam int         PADDR_W      = 3;
	localparam int         PDATA_W      = 32;
	localparam logic [0:0] REG_CRC_SEED = 1'b0;

	// Framing characters and digit bases
	localparam logic [7:0] CH_START = 8'h3C;
	localparam logic [7:0] CH_STOP  = 8'h3E;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] DIGIT_TEN = 8'd10;

	// CRC-8, x^8+x^2+x+1, MSB first
	localparam logic [7:0] CRC_POLY = 8'h07;

	// Flag bits in the flags byte
	localparam int FLAG_FIRST = 0;
	localparam int FLAG_LAST  = 1;

	typedef enum logic [1:0] {
		EV_PAYLOAD   = 2'd0,
		EV_GOOD      = 2'd1,
		EV_CRC_ERR   = 2'd2,
		EV_MALFORMED = 2'd3
	} evt_code_t;

	// Lenient digit mapping; the value wraps in eight bits
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_LC_A) begin
			v = c - CH_LC_A + DIGIT_TEN;
		end else if (c >= CH_UC_A) begin
			v = c - CH_UC_A + DIGIT_TEN;
		end else if (c >= CH_ZERO) begin
			v = c - CH_ZERO;
		end else begin
			v = '0;
		end
		return v;
	endfunction

	// One byte through the CRC register: eight shift/xor steps, an XOR tree
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ahfd_if.sv
// Stream interfaces of the deframer: received characters in, result words out.
// Depends on ahfd_pkg.
`default_nettype none

interface ahfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink   (input valid, input rx_char, output ready);
endinterface

interface ahfd_res_if import ahfd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           event_res;
	logic [7:0]           payload_byte;
	logic [POS_WIDTH-1:0] byte_position;
	logic [3:0]           sender_id;
	logic [3:0]           receiver_id;
	logic                 last_frame;
	logic                 first_frame;
	logic [7:0]           frame_index;
	logic [7:0]           crc_received;
	logic [7:0]           crc_computed;

	modport source (output valid, output event_res, output payload_byte, output byte_position,
		output sender_id, output receiver_id, output last_frame, output first_frame,
		output frame_index, output crc_received, output crc_computed, input ready);
	modport sink (input valid, input event_res, input payload_byte, input byte_position,
		input sender_id, input receiver_id, input last_frame, input first_frame,
		input frame_index, input crc_received, input crc_computed, output ready);
endinterface

`default_nettype wire

### hw/rtl/ascii_hex_frame_deframer_crc8.sv
// ASCII hex frame deframer with CRC-8 check, top level.
// Depends on ahfd_pkg and the stream interfaces in ahfd_if.
//
// Usage:
//   rx  : one received character per word (valid/ready).
//   res : zero or one result word per character: a payload byte, or the
//         frame verdict (good, CRC error, malformed) when '>' arrives.
//   APB : register 0 at byte address 0 is crc_seed, the CRC start value
//         loaded at each '<'. Write it only while the block is idle.
// Timing: a character's frame state and CRC byte update are worked out in
//   the input register; its result then moves to the result register and
//   is visible on res. One character per cycle is taken unless res stalls;
//   the limit is the single input register feeding the result register.
// Stall: while a result waits on res and res.ready is low, the input register
//   is held and rx.ready drops once it is full; no word is lost or repeated.
// Reset: arst_n clears the frame state, the seed and the valid bits of both
//   registers; the block then waits for '<' and ignores everything else.
`default_nettype none

module ascii_hex_frame_deframer_crc8 import ahfd_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	ahfd_rx_if.sink                 rx,
	ahfd_res_if.source              res
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MIN = COUNT_WIDTH'(MIN_PAIRS);
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);

	// Configuration register
	logic [7:0] crc_seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1] == REG_CRC_SEED) begin
			crc_seed_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_CRC_SEED) ?
		{{(PDATA_W-8){1'b0}}, crc_seed_q} : '0;

	// Pipeline control
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	logic       adv;
	logic       proc;

	assign adv      = !out_valid_q || res.ready;
	assign proc     = valid_s1 && adv;
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			char_s1 <= rx.rx_char;
		end
	end

	// Frame state
	logic                   in_frame_q, nxt_in_frame;
	logic                   second_q, nxt_second;
	logic [3:0]             high_q, nxt_high;
	logic                   pend_valid_q, nxt_pend_valid;
	logic [7:0]             pend_byte_q, nxt_pend_byte;
	logic [COUNT_WIDTH-1:0] pair_cnt_q, nxt_pair_cnt;
	logic [7:0]             crc_q, nxt_crc;
	logic [7:0]             addr_q, nxt_addr;
	logic [1:0]             flags_q, nxt_flags;
	logic [7:0]             index_q, nxt_index;

	// Payload offset, saturated to the field width
	logic [COUNT_WIDTH-1:0] pos_diff;
	logic [POS_WIDTH-1:0]   pos_sat;

	assign pos_diff = pair_cnt_q - CNT_MIN;

	generate
		if (COUNT_WIDTH > POS_WIDTH) begin : g_pos_wide
			assign pos_sat = (|pos_diff[COUNT_WIDTH-1:POS_WIDTH]) ? '1 : pos_diff[POS_WIDTH-1:0];
		end else begin : g_pos_narrow
			assign pos_sat = POS_WIDTH'(pos_diff);
		end
	endgenerate

	// Result of the character in the input register
	logic                 r_valid;
	evt_code_t            r_evt;
	logic [7:0]           r_pay;
	logic [POS_WIDTH-1:0] r_pos;
	logic [7:0]           r_crc_rx;
	logic [7:0]           r_crc_calc;
	logic [7:0]           dig;
	logic [7:0]           byte_val;
	logic                 cnt_ge_min;

	always_comb begin
		dig        = digit_value(char_s1);
		byte_val   = {high_q, 4'b0000} | dig;
		cnt_ge_min = pair_cnt_q >= CNT_MIN;

		nxt_in_frame   = in_frame_q;
		nxt_second     = second_q;
		nxt_high       = high_q;
		nxt_pend_valid = pend_valid_q;
		nxt_pend_byte  = pend_byte_q;
		nxt_pair_cnt   = pair_cnt_q;
		nxt_crc        = crc_q;
		nxt_addr       = addr_q;
		nxt_flags      = flags_q;
		nxt_index      = index_q;

		r_valid    = 1'b0;
		r_evt      = EV_PAYLOAD;
		r_pay      = '0;
		r_pos      = '0;
		r_crc_rx   = '0;
		r_crc_calc = '0;

		priority if (char_s1 == CH_START) begin
			// new frame, drops any open one
			nxt_in_frame   = 1'b1;
			nxt_second     = 1'b0;
			nxt_high       = '0;
			nxt_pend_valid = 1'b0;
			nxt_pend_byte  = '0;
			nxt_pair_cnt   = '0;
			nxt_crc        = crc_seed_q;
			nxt_addr       = '0;
			nxt_flags      = '0;
			nxt_index      = '0;
		end else if (!in_frame_q) begin
			// outside a frame: ignored
		end else if (char_s1 == CH_STOP) begin
			// frame verdict
			r_valid = 1'b1;
			if (second_q || !cnt_ge_min) begin
				r_evt = EV_MALFORMED;
			end else begin
				r_evt      = (pend_byte_q == crc_q) ? EV_GOOD : EV_CRC_ERR;
				r_pos      = pos_sat;
				r_crc_rx   = pend_byte_q;
				r_crc_calc = crc_q;
			end
			nxt_in_frame = 1'b0;
			nxt_second   = 1'b0;
		end else if (!second_q) begin
			nxt_high   = dig[3:0];
			nxt_second = 1'b1;
		end else begin
			// pair complete: release the held byte, keep this one back
			nxt_second = 1'b0;
			if (pend_valid_q) begin
				nxt_crc = crc8_byte(crc_q, pend_byte_q);
				if (cnt_ge_min) begin
					r_valid = 1'b1;
					r_pay   = pend_byte_q;
					r_pos   = pos_sat;
				end
			end
			priority if (pair_cnt_q == '0) begin
				nxt_addr = {high_q, dig[3:0]};
			end else if (pair_cnt_q == CNT_ONE) begin
				nxt_flags = byte_val[1:0];
			end else if (pair_cnt_q == CNT_TWO) begin
				nxt_index = byte_val;
			end else begin
				// payload or CRC pair
			end
			nxt_pend_byte  = byte_val;
			nxt_pend_valid = 1'b1;
			if (pair_cnt_q != '1) begin
				nxt_pair_cnt = pair_cnt_q + CNT_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			second_q     <= 1'b0;
			high_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_byte_q  <= '0;
			pair_cnt_q   <= '0;
			crc_q        <= '0;
			addr_q       <= '0;
			flags_q      <= '0;
			index_q      <= '0;
		end else if (proc) begin
			in_frame_q   <= nxt_in_frame;
			second_q     <= nxt_second;
			high_q       <= nxt_high;
			pend_valid_q <= nxt_pend_valid;
			pend_byte_q  <= nxt_pend_byte;
			pair_cnt_q   <= nxt_pair_cnt;
			crc_q        <= nxt_crc;
			addr_q       <= nxt_addr;
			flags_q      <= nxt_flags;
			index_q      <= nxt_index;
		end
	end

	// Result register
	evt_code_t            evt_q;
	logic [7:0]           pay_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [7:0]           addr_out_q;
	logic [1:0]           flags_out_q;
	logic [7:0]           index_out_q;
	logic [7:0]           crc_rx_q;
	logic [7:0]           crc_calc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && r_valid) begin
			evt_q       <= r_evt;
			pay_q       <= r_pay;
			pos_q       <= r_pos;
			addr_out_q  <= addr_q;
			flags_out_q <= flags_q;
			index_out_q <= index_q;
			crc_rx_q    <= r_crc_rx;
			crc_calc_q  <= r_crc_calc;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.event_res     = evt_q;
	assign res.payload_byte  = pay_q;
	assign res.byte_position = pos_q;
	assign res.sender_id     = addr_out_q[7:4];
	assign res.receiver_id   = addr_out_q[3:0];
	assign res.last_frame    = flags_out_q[FLAG_LAST];
	assign res.first_frame   = flags_out_q[FLAG_FIRST];
	assign res.frame_index   = index_out_q;
	assign res.crc_received  = crc_rx_q;
	assign res.crc_computed  = crc_calc_q;

	// Checks
	a_digit_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> in_frame_q)
		else $error("half pair held outside a frame");

	a_pending_counted: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (pair_cnt_q != '0))
		else $error("held byte without a counted pair");

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && out_valid_q && !res.ready))
		else $error("input stalled without a blocked result");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q)) |-> $past(valid_s1))
		else $error("result word without a character behind it");

endmodule

`default_nettype wire
